// ===== rtl/hsv_rgb_led_pwm_duty_unit_defines.svh =====
// Assertion macros shared by the HSV/RGB LED duty unit.
`ifndef HSV_RGB_LED_PWM_DUTY_UNIT_DEFINES_SVH
`define HSV_RGB_LED_PWM_DUTY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HRPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define HRPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/hrpd_pkg.sv =====
// Package: shared types, constants and register map of the LED duty unit.
`default_nettype none

package hrpd_pkg;

   localparam int FRAC_BITS_DEF = 12;

   localparam int BYTE_W  = 8;
   localparam int TOP_W   = 15;
   localparam int GAIN_W  = 11;
   localparam int DUTY_W  = 15;
   localparam int BG_W    = 18;
   localparam int Y_W     = 23;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam logic [GAIN_W-1:0] GAIN_ONE = 11'd1024;
   localparam logic [12:0]       Q12_ONE  = 13'd4096;

   // floor(y / 255) == (y * RECIP_255) >> RECIP_SHIFT for y < 2**23
   localparam logic [23:0] RECIP_255   = 24'd8421505;
   localparam int          RECIP_SHIFT = 31;
   localparam int          RECIP_W     = Y_W + 24;

   localparam logic [TOP_W-1:0]  PWM_TOP_RST    = 15'd10000;
   localparam logic [GAIN_W-1:0] GAIN_RED_RST   = 11'd512;
   localparam logic [GAIN_W-1:0] GAIN_GREEN_RST = 11'd922;
   localparam logic [GAIN_W-1:0] GAIN_BLUE_RST  = 11'd1024;

   typedef enum logic [1:0] {
      REG_PWM_TOP    = 2'd0,
      REG_GAIN_RED   = 2'd1,
      REG_GAIN_GREEN = 2'd2,
      REG_GAIN_BLUE  = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      SEC_R_TO_Y = 3'd0,
      SEC_Y_TO_G = 3'd1,
      SEC_G_TO_C = 3'd2,
      SEC_C_TO_B = 3'd3,
      SEC_B_TO_M = 3'd4,
      SEC_M_TO_R = 3'd5
   } sector_type;

   typedef struct packed {
      logic [TOP_W-1:0]  pwm_top;
      logic [GAIN_W-1:0] gain_red;
      logic [GAIN_W-1:0] gain_green;
      logic [GAIN_W-1:0] gain_blue;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } pixel_type;

endpackage

`default_nettype wire

// ===== rtl/hrpd_hsv_front.sv =====
// Color front end: HSV terms, component products, sector select, bytes and packed-color mode.
`default_nettype none

module hrpd_hsv_front
   import hrpd_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        adv,
   input  wire logic        in_valid,
   input  wire logic        op,
   input  wire logic [11:0] hue,
   input  wire logic [12:0] saturation,
   input  wire logic [12:0] brightness,
   input  wire logic [23:0] packed_color,
   output pixel_type        pixel
);

   localparam int FW  = FRAC_BITS;
   localparam int AW  = FW + 13;
   localparam int CW  = FW + 25;
   localparam int BSH = FW + 24;

   function automatic logic [BYTE_W-1:0] to_byte(input logic [CW-1:0] comp);
      logic [CW+7:0] m;
      logic [CW+7-BSH:0] b;
      m = {comp, 8'b0} - {8'b0, comp};
      b = m[CW+7:BSH];
      to_byte = b[CW+7-BSH:BYTE_W] != '0 ? 8'hFF : b[BYTE_W-1:0];
   endfunction

   // stage 1: saturate, sector, fraction and the three scale terms
   logic [12:0]      s_sat, v_sat;
   logic [14:0]      h6;
   logic [FW+11:0]   f_wide;
   logic [FW-1:0]    ff;
   logic [FW:0]      omf;
   logic [AW-1:0]    full, prod_q, ap_in, aq_in, at_in;
   logic [AW:0]      prod_t;

   logic             s1_valid_ff, s1_op_ff, s1_szero_ff;
   logic [23:0]      s1_pc_ff;
   logic [12:0]      s1_v_ff;
   logic [2:0]       s1_sector_ff;
   logic [AW-1:0]    s1_ap_ff, s1_aq_ff, s1_at_ff;

   always_comb begin
      s_sat  = (saturation > Q12_ONE) ? Q12_ONE : saturation;
      v_sat  = (brightness > Q12_ONE) ? Q12_ONE : brightness;
      h6     = {3'b0, hue} * 15'd6;
      f_wide = {h6[11:0], {FW{1'b0}}};
      ff     = f_wide[FW+11:12];
      omf    = {1'b1, {FW{1'b0}}} - {1'b0, ff};
      full   = {1'b1, {(AW-1){1'b0}}};
      prod_q = AW'(s_sat) * AW'(ff);
      prod_t = (AW+1)'(s_sat) * (AW+1)'(omf);
      ap_in  = {Q12_ONE - s_sat, {FW{1'b0}}};
      aq_in  = full - prod_q;
      at_in  = full - prod_t[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
      end
      if (adv) begin
         s1_op_ff     <= op;
         s1_pc_ff     <= packed_color;
         s1_v_ff      <= v_sat;
         s1_szero_ff  <= (s_sat == '0);
         s1_sector_ff <= h6[14:12];
         s1_ap_ff     <= ap_in;
         s1_aq_ff     <= aq_in;
         s1_at_ff     <= at_in;
      end
   end

   // stage 2: value times each term
   logic [CW:0]   cp_w, cq_w, ct_w;
   logic [CW-1:0] cv_in;

   logic          s2_valid_ff, s2_op_ff, s2_szero_ff;
   logic [23:0]   s2_pc_ff;
   logic [2:0]    s2_sector_ff;
   logic [CW-1:0] s2_cv_ff, s2_cp_ff, s2_cq_ff, s2_ct_ff;

   always_comb begin
      cp_w  = (CW+1)'(s1_v_ff) * (CW+1)'(s1_ap_ff);
      cq_w  = (CW+1)'(s1_v_ff) * (CW+1)'(s1_aq_ff);
      ct_w  = (CW+1)'(s1_v_ff) * (CW+1)'(s1_at_ff);
      cv_in = {s1_v_ff, {(FW+12){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         s2_op_ff     <= s1_op_ff;
         s2_pc_ff     <= s1_pc_ff;
         s2_szero_ff  <= s1_szero_ff;
         s2_sector_ff <= s1_sector_ff;
         s2_cv_ff     <= cv_in;
         s2_cp_ff     <= cp_w[CW-1:0];
         s2_cq_ff     <= cq_w[CW-1:0];
         s2_ct_ff     <= ct_w[CW-1:0];
      end
   end

   // stage 3: sector select, truncate to bytes, mode select
   logic [CW-1:0] cr, cg, cb;
   pixel_type     pixel_in;
   pixel_type     pixel_ff;

   always_comb begin
      if (s2_szero_ff) begin
         cr = s2_cv_ff; cg = s2_cv_ff; cb = s2_cv_ff;
      end else begin
         case (sector_type'(s2_sector_ff))
            SEC_R_TO_Y: begin cr = s2_cv_ff; cg = s2_ct_ff; cb = s2_cp_ff; end
            SEC_Y_TO_G: begin cr = s2_cq_ff; cg = s2_cv_ff; cb = s2_cp_ff; end
            SEC_G_TO_C: begin cr = s2_cp_ff; cg = s2_cv_ff; cb = s2_ct_ff; end
            SEC_C_TO_B: begin cr = s2_cp_ff; cg = s2_cq_ff; cb = s2_cv_ff; end
            SEC_B_TO_M: begin cr = s2_ct_ff; cg = s2_cp_ff; cb = s2_cv_ff; end
            default:    begin cr = s2_cv_ff; cg = s2_cp_ff; cb = s2_cq_ff; end
         endcase
      end
      pixel_in.valid = s2_valid_ff;
      if (s2_op_ff) begin
         pixel_in.red   = s2_pc_ff[23:16];
         pixel_in.green = s2_pc_ff[15:8];
         pixel_in.blue  = s2_pc_ff[7:0];
      end else begin
         pixel_in.red   = to_byte(cr);
         pixel_in.green = to_byte(cg);
         pixel_in.blue  = to_byte(cb);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_ff.valid <= 1'b0;
      end else if (adv) begin
         pixel_ff.valid <= pixel_in.valid;
      end
      if (adv) begin
         pixel_ff.red   <= pixel_in.red;
         pixel_ff.green <= pixel_in.green;
         pixel_ff.blue  <= pixel_in.blue;
      end
   end

   assign pixel = pixel_ff;

endmodule

`default_nettype wire

// ===== rtl/hrpd_duty_scale.sv =====
// Duty scaler: byte times gain, times reload, divided by 255*1024.
`default_nettype none

module hrpd_duty_scale
   import hrpd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire pixel_type         pixel,
   input  wire cfg_type           cfg,
   output logic                   out_valid,
   output logic [DUTY_W-1:0]      duty_red,
   output logic [DUTY_W-1:0]      duty_green,
   output logic [DUTY_W-1:0]      duty_blue
);

   logic [BYTE_W-1:0] byte_a [3];
   logic [GAIN_W-1:0] gain_a [3];
   logic              v4_ff, v5_ff, v6_ff;
   logic [BG_W-1:0]   bg_ff   [3];
   logic [Y_W-1:0]    y_ff    [3];
   logic [DUTY_W-1:0] duty_ff [3];

   always_comb begin
      byte_a[0] = pixel.red;
      byte_a[1] = pixel.green;
      byte_a[2] = pixel.blue;
      gain_a[0] = (cfg.gain_red   > GAIN_ONE) ? GAIN_ONE : cfg.gain_red;
      gain_a[1] = (cfg.gain_green > GAIN_ONE) ? GAIN_ONE : cfg.gain_green;
      gain_a[2] = (cfg.gain_blue  > GAIN_ONE) ? GAIN_ONE : cfg.gain_blue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= pixel.valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [BG_W+TOP_W-1:0] x_in;
      logic [RECIP_W-1:0]    q_in;

      always_comb begin
         x_in = (BG_W+TOP_W)'(bg_ff[i]) * (BG_W+TOP_W)'(cfg.pwm_top);
         q_in = RECIP_W'(y_ff[i]) * RECIP_W'(RECIP_255);
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            bg_ff[i]   <= BG_W'(byte_a[i]) * BG_W'(gain_a[i]);
            y_ff[i]    <= x_in[Y_W+9:10];
            duty_ff[i] <= q_in[RECIP_SHIFT+DUTY_W-1:RECIP_SHIFT];
         end
      end
   end

   assign out_valid  = v6_ff;
   assign duty_red   = duty_ff[0];
   assign duty_green = duty_ff[1];
   assign duty_blue  = duty_ff[2];

endmodule

`default_nettype wire

// ===== rtl/hsv_rgb_led_pwm_duty_unit.sv =====
// Top level: LED color to PWM duty unit with APB-style register port.
//
//   channel  | direction | handshake            | payload
//   req      | in        | req_valid/req_stall  | op, hue, saturation, brightness, packed_color
//   rsp      | out       | rsp_valid/rsp_stall  | duty_red, duty_green, duty_blue
//   csr      | in/out    | psel/penable/pready  | paddr, pwdata, prdata
//
// Six-stage pipeline, one request per cycle while no result is stalled at the output.
// Stages: terms, products, bytes, byte*gain, *reload, reciprocal of 255.
// The whole pipeline holds while a result is stalled at the output register.
// Synchronous reset clears valid bits and loads register defaults.
`default_nettype none

`include "hsv_rgb_led_pwm_duty_unit_defines.svh"

module hsv_rgb_led_pwm_duty_unit
   import hrpd_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_op,
   input  wire logic [11:0]       req_hue,
   input  wire logic [12:0]       req_saturation,
   input  wire logic [12:0]       req_brightness,
   input  wire logic [23:0]       req_packed_color,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [DUTY_W-1:0]      rsp_duty_red,
   output logic [DUTY_W-1:0]      rsp_duty_green,
   output logic [DUTY_W-1:0]      rsp_duty_blue,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0]      prdata,
   output logic                   pready
);

   cfg_type       cfg_ff;
   logic          cfg_wr;
   reg_index_type reg_sel;
   logic          adv;
   pixel_type     pixel;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign reg_sel = reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pwm_top    <= PWM_TOP_RST;
         cfg_ff.gain_red   <= GAIN_RED_RST;
         cfg_ff.gain_green <= GAIN_GREEN_RST;
         cfg_ff.gain_blue  <= GAIN_BLUE_RST;
      end else if (cfg_wr) begin
         case (reg_sel)
            REG_PWM_TOP:    cfg_ff.pwm_top    <= pwdata[TOP_W-1:0];
            REG_GAIN_RED:   cfg_ff.gain_red   <= pwdata[GAIN_W-1:0];
            REG_GAIN_GREEN: cfg_ff.gain_green <= pwdata[GAIN_W-1:0];
            REG_GAIN_BLUE:  cfg_ff.gain_blue  <= pwdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_PWM_TOP:    prdata = DATA_W'(cfg_ff.pwm_top);
         REG_GAIN_RED:   prdata = DATA_W'(cfg_ff.gain_red);
         REG_GAIN_GREEN: prdata = DATA_W'(cfg_ff.gain_green);
         REG_GAIN_BLUE:  prdata = DATA_W'(cfg_ff.gain_blue);
         default:        prdata = '0;
      endcase
   end

   // pipeline moves unless the output holds an undelivered result
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   hrpd_hsv_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (req_valid),
      .op           (req_op),
      .hue          (req_hue),
      .saturation   (req_saturation),
      .brightness   (req_brightness),
      .packed_color (req_packed_color),
      .pixel        (pixel)
   );

   hrpd_duty_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .pixel      (pixel),
      .cfg        (cfg_ff),
      .out_valid  (rsp_valid),
      .duty_red   (rsp_duty_red),
      .duty_green (rsp_duty_green),
      .duty_blue  (rsp_duty_blue)
   );

   `HRPD_ASSERT_NOW(a_red_le_top, clock, reset, rsp_valid, rsp_duty_red <= cfg_ff.pwm_top, "red duty above reload")
   `HRPD_ASSERT_NOW(a_green_le_top, clock, reset, rsp_valid, rsp_duty_green <= cfg_ff.pwm_top, "green duty above reload")
   `HRPD_ASSERT_NOW(a_blue_le_top, clock, reset, rsp_valid, rsp_duty_blue <= cfg_ff.pwm_top, "blue duty above reload")
   `HRPD_ASSERT_NEXT(a_stall_holds_cfg, clock, reset, rsp_valid && rsp_stall && !cfg_wr, $stable(cfg_ff), "config moved while result held")

endmodule

`default_nettype wire
